/* sv/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define HLSH_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every clock edge, reset included
`define HLSH_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/hlsh_pkg.sv */
// shared constants, codes and types of the hyperplane signature core
package hlsh_pkg;

  localparam int MAX_BITS     = 64;
  localparam int MAX_DIMS     = 64;
  localparam int MAX_SEGMENTS = 256;
  localparam int SAMPLE_WIDTH = 16;

  localparam int ROW_W    = $clog2(MAX_BITS);
  localparam int COL_W    = $clog2(MAX_DIMS);
  localparam int COEF_AW  = ROW_W + COL_W;
  localparam int SEG_AW   = $clog2(MAX_SEGMENTS);
  localparam int ACC_W    = 40;
  localparam int PROD_W   = 2 * SAMPLE_WIDTH;
  localparam int FRAME_W  = 24;
  localparam int SIG_W    = 64;
  localparam int DIMS_W   = 7;
  localparam int SEGCNT_W = 9;
  localparam int CFG_W    = 9;
  localparam int CFG_IW   = 2;

  localparam logic [FRAME_W-1:0] FRAME_MAX = '1;
  localparam logic [DIMS_W-1:0]  COUNT_MAX = '1;

  // register indexes of the configuration port
  localparam logic [CFG_IW-1:0] CFG_NUM_DIMS  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_WIDE_SIG  = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_SEG_COUNT = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD_COEF = 2'd0,
    OP_LOAD_SEG  = 2'd1,
    OP_ELEMENT   = 2'd2,
    OP_RESTART   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_FIN,
    ST_SEG_CHK,
    ST_SEG_NEXT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                           en;
    logic [COEF_AW-1:0]             addr;
    logic signed [SAMPLE_WIDTH-1:0] data;
  } coef_wr_t;

  typedef struct packed {
    logic               en;
    logic [SEG_AW-1:0]  addr;
    logic [FRAME_W-1:0] start_frame;
    logic [FRAME_W-1:0] end_frame;
  } seg_wr_t;

  typedef struct packed {
    logic                           start;
    logic                           clear;
    logic [COL_W-1:0]               element;
    logic signed [SAMPLE_WIDTH-1:0] sample;
  } mac_ctrl_t;

endpackage

/* sv/hlsh_seg_table.sv */
// voice segment table: one write port, one registered read port
module hlsh_seg_table
  import hlsh_pkg::*;
(
  input  logic               clk,
  input  seg_wr_t            wr,
  input  logic [SEG_AW-1:0]  rd_addr,
  output logic [FRAME_W-1:0] rd_start,
  output logic [FRAME_W-1:0] rd_end
);

  logic [2*FRAME_W-1:0] seg_mem [2**SEG_AW];
  logic [2*FRAME_W-1:0] rd_q;

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      seg_mem[wr.addr] <= {wr.end_frame, wr.start_frame};
    end
    rd_q <= seg_mem[rd_addr];
  end

  assign rd_start = rd_q[FRAME_W-1:0];
  assign rd_end   = rd_q[2*FRAME_W-1:FRAME_W];

endmodule

/* sv/hlsh_mac_engine.sv */
// coefficient memory, accumulator memory and the row-serial multiply-accumulate
module hlsh_mac_engine
  import hlsh_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  coef_wr_t            coef_wr,
  input  mac_ctrl_t           ctrl,
  output logic                busy,
  output logic [MAX_BITS-1:0] signs
);

  logic signed [SAMPLE_WIDTH-1:0] coef_mem [2**COEF_AW];
  logic [ACC_W-1:0]               acc_mem [MAX_BITS];

  logic                           run;
  logic [ROW_W-1:0]               rd_row;
  logic signed [SAMPLE_WIDTH-1:0] sample_q;
  logic [COL_W-1:0]               elem_q;
  logic [MAX_BITS-1:0]            acc_valid;

  logic                           p1_v;
  logic [ROW_W-1:0]               p1_row;
  logic signed [SAMPLE_WIDTH-1:0] coef_q;
  logic [ACC_W-1:0]               acc_q;

  logic                           p2_v;
  logic [ROW_W-1:0]               p2_row;
  logic signed [PROD_W-1:0]       p2_prod;
  logic [ACC_W-1:0]               p2_acc;

  logic signed [PROD_W-1:0]       prod;
  logic [ACC_W-1:0]               sum;

  // stage one product, stage two add
  assign prod = sample_q * coef_q;
  assign sum  = p2_acc + {{(ACC_W-PROD_W){p2_prod[PROD_W-1]}}, p2_prod};
  assign busy = run | p1_v | p2_v;

  // coefficient memory
  always_ff @(posedge clk) begin
    if (coef_wr.en) begin
      coef_mem[coef_wr.addr] <= coef_wr.data;
    end
    coef_q <= coef_mem[{rd_row, elem_q}];
  end

  // accumulator memory, read one row while an earlier row is written back
  always_ff @(posedge clk) begin
    if (p2_v) begin
      acc_mem[p2_row] <= sum;
    end
    acc_q <= acc_mem[rd_row];
  end

  // row sequencer and pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      run       <= 1'b0;
      rd_row    <= '0;
      p1_v      <= 1'b0;
      p2_v      <= 1'b0;
      acc_valid <= '0;
      signs     <= '1;
    end else begin
      if (ctrl.start) begin
        run    <= 1'b1;
        rd_row <= '0;
      end else if (run) begin
        if (rd_row == ROW_W'(MAX_BITS - 1)) begin
          run <= 1'b0;
        end
        rd_row <= rd_row + 1'b1;
      end
      p1_v <= run;
      p2_v <= p1_v;
      if (p2_v) begin
        acc_valid[p2_row] <= 1'b1;
        signs[p2_row]     <= ~sum[ACC_W-1];
      end
      // cleared accumulators read as zero, which is non-negative
      if (ctrl.clear) begin
        acc_valid <= '0;
        signs     <= '1;
      end
    end
  end

  // payload of the pipeline
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      sample_q <= ctrl.sample;
      elem_q   <= ctrl.element;
    end
    p1_row  <= rd_row;
    p2_row  <= p1_row;
    p2_prod <= prod;
    p2_acc  <= acc_valid[p1_row] ? acc_q : '0;
  end

endmodule

/* sv/hyperplane_lsh_signature_core.sv */
// top level of the hyperplane signature core
// Each input word carries an opcode in tuser. Coefficient loads, segment loads and
// stream restarts do not hold off the next word. A feature element inside num_dims
// holds off input while one multiply-accumulate unit walks the 64 hyperplane rows,
// one row per cycle, over the coefficient and accumulator memories and through its
// product and add stages, until the unit has drained. Elements beyond num_dims start
// no multiply-accumulate work. The final element of a frame (tlast) adds the frame
// count update and the segment table lookup, holds while an earlier result word is
// still waiting, and the result word then waits in the output register until taken;
// the next input word is accepted meanwhile. Signature bit b is set when the
// projection on row b is zero or more; the upper 32 bits are zero unless
// wide_signature is set, and unvoiced frames give an all-zero signature.
module hyperplane_lsh_signature_core
  import hlsh_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // row, column, sample, seg_slot, seg_first, seg_final, zero pad
  input  logic [87:0]       s_tdata,
  // opcode
  input  logic [1:0]        s_tuser,
  input  logic              s_tlast,
  input  logic              s_tvalid,
  output logic              s_tready,
  // signature, frame_number
  output logic [87:0]       m_tdata,
  // voiced
  output logic [0:0]        m_tuser,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  state_t state, state_next;

  logic [DIMS_W-1:0]   num_dims;
  logic                wide_sig;
  logic [SEGCNT_W-1:0] seg_count;

  logic [DIMS_W-1:0]   ecnt;
  logic                last_q;
  logic [FRAME_W-1:0]  fc;
  logic [SEGCNT_W-1:0] ptr;
  logic                voiced_q;

  logic [SIG_W-1:0]    sig_q;
  logic [FRAME_W-1:0]  frame_q;
  logic                out_voiced;

  // input word fields
  opcode_t                        op;
  logic [5:0]                     in_row;
  logic [5:0]                     in_col;
  logic signed [SAMPLE_WIDTH-1:0] in_sample;
  logic [7:0]                     in_slot;
  logic [FRAME_W-1:0]             in_first;
  logic [FRAME_W-1:0]             in_final;

  logic                in_acc;
  logic                out_free;
  logic                out_load;
  logic [DIMS_W-1:0]   dims;
  logic [SEGCNT_W-1:0] segs;
  logic [FRAME_W-1:0]  fc_inc;
  logic                elem_use;
  logic                advance;
  logic                voiced_chk;

  coef_wr_t            coef_wr;
  seg_wr_t             seg_wr;
  mac_ctrl_t           mac_ctrl;
  logic                mac_busy;
  logic [MAX_BITS-1:0] signs;
  logic [SEG_AW-1:0]   seg_rd_addr;
  logic [FRAME_W-1:0]  seg_start;
  logic [FRAME_W-1:0]  seg_end;
  logic [SIG_W-1:0]    sig_full;

  assign op        = opcode_t'(s_tuser);
  assign in_row    = s_tdata[5:0];
  assign in_col    = s_tdata[11:6];
  assign in_sample = s_tdata[27:12];
  assign in_slot   = s_tdata[35:28];
  assign in_first  = s_tdata[59:36];
  assign in_final  = s_tdata[83:60];

  // handshake and limits
  assign in_acc   = s_tvalid & s_tready;
  assign out_free = ~m_tvalid | m_tready;
  assign dims     = (num_dims > DIMS_W'(MAX_DIMS)) ? DIMS_W'(MAX_DIMS) : num_dims;
  assign segs     = (seg_count > SEGCNT_W'(MAX_SEGMENTS)) ? SEGCNT_W'(MAX_SEGMENTS)
                                                         : seg_count;
  assign fc_inc   = (fc == FRAME_MAX) ? fc : fc + 1'b1;
  assign elem_use = ecnt < dims;

  // segment checks against the entry at the pointer
  assign advance    = (segs != '0) && (ptr < segs) && (fc > seg_end);
  assign voiced_chk = (segs == '0) || ((ptr < segs) && (fc >= seg_start));

  // store writes
  always_comb begin
    coef_wr.en   = in_acc && (op == OP_LOAD_COEF) && (int'(in_row) < MAX_BITS)
                   && (int'(in_col) < MAX_DIMS);
    coef_wr.addr = {in_row[ROW_W-1:0], in_col[COL_W-1:0]};
    coef_wr.data = in_sample;
    seg_wr.en          = in_acc && (op == OP_LOAD_SEG) && (int'(in_slot) < MAX_SEGMENTS);
    seg_wr.addr        = in_slot[SEG_AW-1:0];
    seg_wr.start_frame = in_first;
    seg_wr.end_frame   = in_final;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && (op == OP_ELEMENT)) begin
          if (elem_use) begin
            state_next = ST_MAC;
          end else if (s_tlast) begin
            state_next = ST_FIN;
          end
        end
      end
      ST_MAC: begin
        if (!mac_busy) begin
          state_next = last_q ? ST_FIN : ST_IDLE;
        end
      end
      ST_FIN:      state_next = ST_SEG_CHK;
      ST_SEG_CHK:  state_next = advance ? ST_SEG_NEXT : ST_EMIT;
      ST_SEG_NEXT: state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_tready         = (state == ST_IDLE);
    out_load         = (state == ST_EMIT) && out_free;
    mac_ctrl.start   = in_acc && (op == OP_ELEMENT) && elem_use;
    mac_ctrl.clear   = (in_acc && (op == OP_RESTART)) || out_load;
    mac_ctrl.element = ecnt[COL_W-1:0];
    mac_ctrl.sample  = in_sample;
    seg_rd_addr      = (state == ST_SEG_CHK) ? SEG_AW'(ptr + 1'b1) : ptr[SEG_AW-1:0];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_dims  <= DIMS_W'(39);
      wide_sig  <= 1'b0;
      seg_count <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUM_DIMS:  num_dims  <= cfg_data[DIMS_W-1:0];
        CFG_WIDE_SIG:  wide_sig  <= cfg_data[0];
        CFG_SEG_COUNT: seg_count <= cfg_data[SEGCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // frame control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      ecnt     <= '0;
      last_q   <= 1'b0;
      fc       <= '0;
      ptr      <= '0;
      voiced_q <= 1'b0;
    end else begin
      state <= state_next;
      if (in_acc && (op == OP_RESTART)) begin
        ecnt <= '0;
        fc   <= '0;
        ptr  <= '0;
      end
      if (in_acc && (op == OP_ELEMENT)) begin
        last_q <= s_tlast;
        if (ecnt != COUNT_MAX) begin
          ecnt <= ecnt + 1'b1;
        end
      end
      if (state == ST_FIN) begin
        fc <= fc_inc;
      end
      if (state == ST_SEG_CHK) begin
        if (advance) begin
          ptr <= ptr + 1'b1;
        end else begin
          voiced_q <= voiced_chk;
        end
      end
      if (state == ST_SEG_NEXT) begin
        voiced_q <= (ptr < segs) && (fc >= seg_start);
      end
      if (out_load) begin
        ecnt <= '0;
      end
    end
  end

  // output register
  assign sig_full = wide_sig ? SIG_W'(signs) : SIG_W'(signs[31:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sig_q      <= voiced_q ? sig_full : '0;
      frame_q    <= fc;
      out_voiced <= voiced_q;
    end
  end

  assign m_tdata = {frame_q, sig_q};
  assign m_tuser = out_voiced;

  hlsh_mac_engine u_mac (
    .clk     (clk),
    .rst     (rst),
    .coef_wr (coef_wr),
    .ctrl    (mac_ctrl),
    .busy    (mac_busy),
    .signs   (signs)
  );

  hlsh_seg_table u_seg (
    .clk      (clk),
    .wr       (seg_wr),
    .rd_addr  (seg_rd_addr),
    .rd_start (seg_start),
    .rd_end   (seg_end)
  );

endmodule

/* sv/hlsh_checker.sv */
// port-level checks of the hyperplane signature core and their binding
`include "assert_macros.svh"

module hlsh_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic [87:0] m_tdata,
  input logic [0:0]  m_tuser,
  input logic        m_tvalid,
  input logic        m_tready
);

  // no result word straight after reset
  `HLSH_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !m_tvalid, "result word after reset")

  // a stalled result word holds
  `HLSH_ASSERT(a_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result word changed")

  // unvoiced frames carry an empty signature
  `HLSH_ASSERT(a_unvoiced_zero, clk, rst, m_tvalid && !m_tuser[0] |-> m_tdata[63:0] == 64'd0, "unvoiced frame with signature bits")

  // frame numbers start at one
  `HLSH_ASSERT(a_frame_nonzero, clk, rst, m_tvalid |-> m_tdata[87:64] != 24'd0, "frame number zero")

  // a result word appears only while input is held off
  `HLSH_ASSERT(a_emit_busy, clk, rst, $rose(m_tvalid) |-> !$past(s_tready), "result word raised while idle")

endmodule

bind hyperplane_lsh_signature_core hlsh_checker u_hlsh_checker (.*);

/* sim/hyperplane_lsh_signature_core_tb.sv */
// self-checking testbench for the hyperplane signature core
`timescale 1ns / 100ps

module hyperplane_lsh_signature_core_tb;
  import hlsh_pkg::*;

  // element words hold off input for the whole row walk, frame end adds the segment lookup
  localparam int SETTLE_CYCLES = 120;
  localparam int RUN_LIMIT_NS  = 10_000_000;
  localparam int RANDOM_PHASES = 16;
  localparam int PHASE_WORDS   = 50;
  // coefficient columns loaded for every row; frames never use more
  localparam int FILL_COLS     = 8;

  // one input word, fields as the block sees them
  typedef struct packed {
    opcode_t                        op;
    logic [ROW_W-1:0]               row;
    logic [COL_W-1:0]               column;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic [SEG_AW-1:0]              seg_slot;
    logic [FRAME_W-1:0]             seg_first;
    logic [FRAME_W-1:0]             seg_final;
    logic                           frame_end;
  } lsh_word_t;

  // one result word
  typedef struct packed {
    logic [SIG_W-1:0]   signature;
    logic [FRAME_W-1:0] frame_number;
    logic               voiced;
  } sig_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic [87:0]       s_tdata = '0;
  logic [1:0]        s_tuser = '0;
  logic              s_tlast = 1'b0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [87:0]       m_tdata;
  logic [0:0]        m_tuser;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;

  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // predictor state
  logic signed [SAMPLE_WIDTH-1:0] coef_mem [0:MAX_BITS*MAX_DIMS-1];
  logic [FRAME_W-1:0]             seg_lo_mem [0:MAX_SEGMENTS-1];
  logic [FRAME_W-1:0]             seg_hi_mem [0:MAX_SEGMENTS-1];
  longint                         proj_acc [0:MAX_BITS-1];
  int                             elem_count;
  int                             frame_count;
  int                             seg_ptr;
  int                             cfg_num_dims;
  int                             cfg_wide;
  int                             cfg_seg_count;

  sig_result_t expected_sigs [$];

  hyperplane_lsh_signature_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("DONE: errors detected");
    $finish;
  end

  // receiver side back-pressure
  initial begin
    forever begin
      @(posedge clk);
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // compare every taken result word with the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_result();
  end

  task automatic check_result();
    sig_result_t want;
    if (expected_sigs.size() == 0) begin
      $error("result word with none expected: signature %h frame %0d voiced %0d",
             m_tdata[63:0], m_tdata[87:64], m_tuser[0]);
      errors++;
    end else begin
      want = expected_sigs.pop_front();
      if (m_tdata[63:0] !== want.signature) begin
        $error("signature: expected %h, actual %h", want.signature, m_tdata[63:0]);
        errors++;
      end
      if (m_tdata[87:64] !== want.frame_number) begin
        $error("frame_number: expected %0d, actual %0d", want.frame_number, m_tdata[87:64]);
        errors++;
      end
      if (m_tuser[0] !== want.voiced) begin
        $error("voiced: expected %0d, actual %0d", want.voiced, m_tuser[0]);
        errors++;
      end
    end
  endtask

  function automatic void clear_projections();
    for (int b = 0; b < MAX_BITS; b++) proj_acc[b] = 0;
    elem_count = 0;
  endfunction

  function automatic void reset_predictor();
    for (int i = 0; i < MAX_BITS * MAX_DIMS; i++) coef_mem[i] = '0;
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      seg_lo_mem[i] = '0;
      seg_hi_mem[i] = '0;
    end
    clear_projections();
    frame_count = 0;
    seg_ptr = 0;
    cfg_num_dims = 39;
    cfg_wide = 0;
    cfg_seg_count = 0;
  endfunction

  // work out the effect of one accepted word, queue the signature it gives
  function automatic void predict_signature(input lsh_word_t w);
    int          dims;
    int          segs;
    int          nbits;
    logic        voiced;
    sig_result_t res;
    case (w.op)
      OP_LOAD_COEF: coef_mem[{w.row, w.column}] = w.sample;
      OP_LOAD_SEG: begin
        seg_lo_mem[w.seg_slot] = w.seg_first;
        seg_hi_mem[w.seg_slot] = w.seg_final;
      end
      OP_RESTART: begin
        clear_projections();
        frame_count = 0;
        seg_ptr = 0;
      end
      default: begin
        dims = (cfg_num_dims < MAX_DIMS) ? cfg_num_dims : MAX_DIMS;
        if (elem_count < dims) begin
          for (int b = 0; b < MAX_BITS; b++)
            proj_acc[b] += longint'($signed(w.sample)) *
                           longint'(coef_mem[b * MAX_DIMS + elem_count]);
        end
        if (elem_count < int'(COUNT_MAX)) elem_count++;
        if (w.frame_end) begin
          segs = (cfg_seg_count < MAX_SEGMENTS) ? cfg_seg_count : MAX_SEGMENTS;
          nbits = cfg_wide ? 64 : 32;
          if (frame_count < int'(FRAME_MAX)) frame_count++;
          if (segs == 0) begin
            voiced = 1'b1;
          end else begin
            if (seg_ptr < segs && frame_count > int'(seg_hi_mem[seg_ptr])) seg_ptr++;
            voiced = (seg_ptr < segs) && (frame_count >= int'(seg_lo_mem[seg_ptr]));
          end
          res.signature = '0;
          if (voiced) begin
            for (int b = 0; b < nbits; b++) res.signature[b] = (proj_acc[b] >= 0);
          end
          res.frame_number = FRAME_W'(frame_count);
          res.voiced = voiced;
          expected_sigs.push_back(res);
          clear_projections();
        end
      end
    endcase
  endfunction

  // sample with the extremes and zero turning up often
  function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
    case ($urandom_range(19))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return '0;
      default: return SAMPLE_WIDTH'($urandom);
    endcase
  endfunction

  // all fields random; constructors below override what matters
  function automatic lsh_word_t random_word();
    lsh_word_t w;
    w.op = opcode_t'($urandom_range(3));
    w.row = ROW_W'($urandom);
    w.column = COL_W'($urandom);
    w.sample = pick_sample();
    w.seg_slot = SEG_AW'($urandom);
    w.seg_first = FRAME_W'($urandom);
    w.seg_final = FRAME_W'($urandom);
    w.frame_end = 1'($urandom);
    return w;
  endfunction

  function automatic lsh_word_t element_word(input logic signed [SAMPLE_WIDTH-1:0] smp,
                                             input logic last);
    lsh_word_t w;
    w = random_word();
    w.op = OP_ELEMENT;
    w.sample = smp;
    w.frame_end = last;
    return w;
  endfunction

  function automatic lsh_word_t coef_word(input int r, input int c,
                                          input logic signed [SAMPLE_WIDTH-1:0] smp);
    lsh_word_t w;
    w = random_word();
    w.op = OP_LOAD_COEF;
    w.row = ROW_W'(r);
    w.column = COL_W'(c);
    w.sample = smp;
    return w;
  endfunction

  function automatic lsh_word_t seg_word(input int slot, input int unsigned lo,
                                         input int unsigned hi);
    lsh_word_t w;
    w = random_word();
    w.op = OP_LOAD_SEG;
    w.seg_slot = SEG_AW'(slot);
    w.seg_first = FRAME_W'(lo);
    w.seg_final = FRAME_W'(hi);
    return w;
  endfunction

  function automatic lsh_word_t restart_word();
    lsh_word_t w;
    w = random_word();
    w.op = OP_RESTART;
    return w;
  endfunction

  // offer one word, with a random gap first; valid stays up after acceptance
  task automatic send_word(input lsh_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'b0, w.seg_final, w.seg_first, w.seg_slot, w.sample, w.column, w.row};
    s_tuser <= w.op;
    s_tlast <= w.frame_end;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_signature(w);
  endtask

  // hold the sender until every predicted word is back and the core has settled
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_sigs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(val);
    @(posedge clk);
    case (idx)
      CFG_NUM_DIMS:  cfg_num_dims = val & 127;
      CFG_WIDE_SIG:  cfg_wide = val & 1;
      CFG_SEG_COUNT: cfg_seg_count = val & 511;
      default: ;
    endcase
  endtask

  task automatic configure(input int nd, input int wide, input int segs);
    wait_drained();
    write_reg(CFG_NUM_DIMS, nd);
    write_reg(CFG_WIDE_SIG, wide);
    write_reg(CFG_SEG_COUNT, segs);
    cfg_we <= 1'b0;
  endtask

  task automatic set_idling(input int kind);
    case (kind)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
      default: begin send_idle_pct = 30; recv_stall_pct = 30; end
    endcase
  endtask

  // fill the segment table and the coefficient columns in use for every row,
  // so that no frame ever reads an unwritten entry
  task automatic test_store_loads();
    for (int r = 0; r < MAX_BITS; r++)
      for (int c = 0; c < FILL_COLS; c++) send_word(coef_word(r, c, pick_sample()));
    for (int s = 0; s < MAX_SEGMENTS; s++)
      send_word(seg_word(s, $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF)));
  endtask

  // full-scale coefficients against full-scale samples, wide signature
  task automatic test_sample_extremes();
    configure(3, 1, 0);
    send_word(coef_word(0, 0, 16'sh7FFF));
    send_word(coef_word(63, 0, 16'sh8000));
    send_word(element_word(16'sh7FFF, 1'b0));
    send_word(element_word(16'sh8000, 1'b0));
    send_word(element_word(16'sh0000, 1'b1));
  endtask

  // excess elements, a short all-zero frame and a restart part way through
  task automatic test_frame_lengths();
    configure(3, 1, 0);
    for (int i = 0; i < 5; i++) send_word(element_word(pick_sample(), i == 4));
    send_word(element_word(16'sh0000, 1'b1));
    send_word(element_word(pick_sample(), 1'b0));
    send_word(element_word(pick_sample(), 1'b0));
    send_word(restart_word());
    for (int i = 0; i < 3; i++) send_word(element_word(pick_sample(), i == 2));
  endtask

  // no dimensions in use: every projection is zero
  task automatic test_zero_dims();
    configure(0, 0, 0);
    send_word(element_word(pick_sample(), 1'b1));
  endtask

  // two segments walked through frame by frame, past the last one
  task automatic test_voice_segments();
    configure(1, 0, 2);
    send_word(seg_word(0, 2, 3));
    send_word(seg_word(1, 5, 5));
    send_word(restart_word());
    for (int i = 0; i < 6; i++) send_word(element_word(pick_sample(), 1'b1));
  endtask

  // mostly well-formed frames on one random setting, with some noise
  task automatic test_random_phase(input int phase);
    int          nd;
    int          wide;
    int          segs;
    int          n_ok;
    int          dims;
    int          flen;
    int          sent;
    int          pick;
    int unsigned lo;
    int unsigned hi;
    int unsigned cursor;
    set_idling(phase % 4);
    // dimensions stay within the loaded coefficient columns
    case (phase % 8)
      0: nd = $urandom_range(1, 6);
      1: nd = 1;
      2: nd = FILL_COLS;
      3: nd = 0;
      4: nd = $urandom_range(2, FILL_COLS);
      5: nd = FILL_COLS - 1;
      6: nd = $urandom_range(1, FILL_COLS);
      default: nd = $urandom_range(1, 4);
    endcase
    wide = (phase / 2) % 2;
    n_ok = $urandom_range(1, 8);
    case (phase % 5)
      0: segs = 0;
      1: segs = n_ok;
      2: segs = 256;
      3: segs = 511;
      default: segs = $urandom_range(1, 20);
    endcase
    configure(nd, wide, segs);
    sent = 0;
    // rising frame ranges from frame one, now and then an empty one
    if (segs != 0) begin
      cursor = 1;
      for (int i = 0; i < n_ok; i++) begin
        lo = cursor + $urandom_range(0, 3);
        hi = lo + $urandom_range(0, 4);
        if ($urandom_range(15) == 0) hi = lo - 1;
        send_word(seg_word(i, lo, hi));
        cursor = ((hi > lo) ? hi : lo) + 1;
        sent++;
      end
    end
    send_word(restart_word());
    sent++;
    dims = (nd < MAX_DIMS) ? nd : MAX_DIMS;
    if (dims == 0) dims = 1;
    while (sent < PHASE_WORDS) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_word(random_word());
        sent++;
      end else if (pick < 10) begin
        wait_drained();
      end else begin
        if (pick < 82) flen = dims;
        else if (pick < 91) flen = $urandom_range(1, dims);
        else flen = dims + $urandom_range(1, 3);
        for (int i = 0; i < flen; i++) begin
          if (i > 0 && $urandom_range(33) == 0) begin
            send_word(restart_word());
            sent++;
          end
          send_word(element_word(pick_sample(), i == flen - 1));
          sent++;
        end
      end
    end
  endtask

  // test sequence
  initial begin
    reset_predictor();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    set_idling(0);
    test_store_loads();
    test_sample_extremes();
    test_frame_lengths();
    test_zero_dims();
    test_voice_segments();
    for (int p = 0; p < RANDOM_PHASES; p++) test_random_phase(p);
    wait_drained();
    if (expected_sigs.size() != 0) begin
      $error("%0d result words never arrived", expected_sigs.size());
      errors++;
    end
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/hlsh_pkg.sv
sv/hlsh_seg_table.sv
sv/hlsh_mac_engine.sv
sv/hyperplane_lsh_signature_core.sv
sv/hlsh_checker.sv
sim/hyperplane_lsh_signature_core_tb.sv
